// File: src/cc20_pkg.sv
// Shared types, constants and helpers for the ChaCha20 keystream generator.
`timescale 1ns / 1ps

package cc20_pkg;

    typedef logic [31:0] t_word;
    typedef logic [6:0]  t_count;
    typedef logic [7:0]  t_byte;

    localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
    localparam int unsigned STEPS_PER_DROUND  = 8;
    localparam int unsigned CFG_AW            = 3;
    localparam int unsigned CFG_DW            = 64;

    localparam t_count BLOCK_BYTES = 7'd64;

    localparam t_word SIGMA [4] = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574};

    localparam logic [CFG_AW-1:0] REG_KEY01   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KEY23   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_KEY45   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_KEY67   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_NONCE01 = 3'd4;
    localparam logic [CFG_AW-1:0] REG_NONCE2  = 3'd5;
    localparam logic [CFG_AW-1:0] REG_START   = 3'd6;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_RESTART  = 1'b1;

    localparam logic [1:0] STEP_A16 = 2'd0;
    localparam logic [1:0] STEP_C12 = 2'd1;
    localparam logic [1:0] STEP_A8  = 2'd2;
    localparam logic [1:0] STEP_C7  = 2'd3;

    localparam int unsigned ROT_16 = 16;
    localparam int unsigned ROT_12 = 12;
    localparam int unsigned ROT_8  = 8;
    localparam int unsigned ROT_7  = 7;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       diag;
        logic [1:0] sel;
        logic       fin;
        logic       restart;
        logic       emit;
        logic [5:0] pos;
    } t_cmd;

    function automatic t_word rotl(t_word v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

endpackage

// File: src/cc20_req_if.sv
// Request channel: op and byte count with valid/ready.
`timescale 1ns / 1ps

interface cc20_req_if;
    import cc20_pkg::*;

    logic   valid;
    logic   ready;
    logic   op;
    t_count count;

    modport source (output valid, output op, output count, input ready);
    modport sink   (input valid, input op, input count, output ready);
endinterface

// File: src/cc20_rsp_if.sv
// Response channel: keystream byte and last flag with valid/ready.
`timescale 1ns / 1ps

interface cc20_rsp_if;
    import cc20_pkg::*;

    logic  valid;
    logic  ready;
    t_byte stream_byte;
    logic  last;

    modport source (output valid, output stream_byte, output last, input ready);
    modport sink   (input valid, input stream_byte, input last, output ready);
endinterface

// File: src/cc20_datapath.sv
// Datapath: config registers, block counter, working words, round unit, output byte.
`timescale 1ns / 1ps

module cc20_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [cc20_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [cc20_pkg::CFG_DW-1:0]  i_cfg_wdata,
    input  cc20_pkg::t_cmd               i_cmd,
    output cc20_pkg::t_byte              o_byte
);
    import cc20_pkg::*;

    t_word r_key [8];
    t_word r_nonce [3];
    t_word r_start;
    t_word r_counter;
    t_word r_w [16];
    t_byte r_byte;

    t_word      init_w [16];
    t_word      n_step [16];
    logic [1:0] bi [4];
    logic [1:0] ci [4];
    logic [1:0] di [4];
    t_word      qa [4];
    t_word      qb [4];
    t_word      qc [4];
    t_word      qd [4];
    t_word      na [4];
    t_word      nb [4];
    t_word      nc [4];
    t_word      nd [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            init_w[i] = SIGMA[i];
        end
        for (int i = 0; i < 8; i++) begin
            init_w[4 + i] = r_key[i];
        end
        init_w[12] = r_counter;
        init_w[13] = r_nonce[0];
        init_w[14] = r_nonce[1];
        init_w[15] = r_nonce[2];
    end

    always_comb begin
        n_step = r_w;
        for (int i = 0; i < 4; i++) begin
            bi[i] = 2'(i) + {1'b0, i_cmd.diag};
            ci[i] = 2'(i) + {i_cmd.diag, 1'b0};
            di[i] = 2'(i) + {i_cmd.diag, i_cmd.diag};
            qa[i] = r_w[{2'b00, 2'(i)}];
            qb[i] = r_w[{2'b01, bi[i]}];
            qc[i] = r_w[{2'b10, ci[i]}];
            qd[i] = r_w[{2'b11, di[i]}];
            na[i] = qa[i];
            nb[i] = qb[i];
            nc[i] = qc[i];
            nd[i] = qd[i];
            unique case (i_cmd.sel)
                STEP_A16: begin
                    na[i] = qa[i] + qb[i];
                    nd[i] = rotl(qd[i] ^ na[i], ROT_16);
                end
                STEP_C12: begin
                    nc[i] = qc[i] + qd[i];
                    nb[i] = rotl(qb[i] ^ nc[i], ROT_12);
                end
                STEP_A8: begin
                    na[i] = qa[i] + qb[i];
                    nd[i] = rotl(qd[i] ^ na[i], ROT_8);
                end
                STEP_C7: begin
                    nc[i] = qc[i] + qd[i];
                    nb[i] = rotl(qb[i] ^ nc[i], ROT_7);
                end
                default: begin
                    na[i] = qa[i];
                end
            endcase
            n_step[{2'b00, 2'(i)}] = na[i];
            n_step[{2'b01, bi[i]}] = nb[i];
            n_step[{2'b10, ci[i]}] = nc[i];
            n_step[{2'b11, di[i]}] = nd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_key[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_nonce[i] <= '0;
            end
            r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_KEY01: begin
                    r_key[0] <= i_cfg_wdata[31:0];
                    r_key[1] <= i_cfg_wdata[63:32];
                end
                REG_KEY23: begin
                    r_key[2] <= i_cfg_wdata[31:0];
                    r_key[3] <= i_cfg_wdata[63:32];
                end
                REG_KEY45: begin
                    r_key[4] <= i_cfg_wdata[31:0];
                    r_key[5] <= i_cfg_wdata[63:32];
                end
                REG_KEY67: begin
                    r_key[6] <= i_cfg_wdata[31:0];
                    r_key[7] <= i_cfg_wdata[63:32];
                end
                REG_NONCE01: begin
                    r_nonce[0] <= i_cfg_wdata[31:0];
                    r_nonce[1] <= i_cfg_wdata[63:32];
                end
                REG_NONCE2: begin
                    r_nonce[2] <= i_cfg_wdata[31:0];
                end
                REG_START: begin
                    r_start <= i_cfg_wdata[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
        end else if (i_cmd.restart) begin
            r_counter <= r_start;
        end else if (i_cmd.fin) begin
            r_counter <= r_counter + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= init_w;
        end else if (i_cmd.step) begin
            r_w <= n_step;
        end else if (i_cmd.fin) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= r_w[i] + init_w[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte <= r_w[i_cmd.pos[5:2]][{i_cmd.pos[1:0], 3'b000} +: 8];
        end
    end

    assign o_byte = r_byte;

endmodule

// File: src/cc20_ctrl.sv
// Controller: request intake, round sequencing, byte emission and output handshake.
`timescale 1ns / 1ps

module cc20_ctrl #(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_op,
    input  cc20_pkg::t_count i_req_count,
    output logic             o_req_ready,
    output logic             o_rsp_valid,
    output logic             o_rsp_last,
    input  logic             i_rsp_ready,
    output cc20_pkg::t_cmd   o_cmd
);
    import cc20_pkg::*;

    localparam int unsigned ROUND_STEPS = DOUBLE_ROUNDS * STEPS_PER_DROUND;
    localparam int unsigned CNT_W       = $clog2(ROUND_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROUND_STEPS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_INIT  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_count           r_bytes_left, n_bytes_left;
    t_count           r_remain, n_remain;
    logic             r_out_valid, n_out_valid;
    logic             r_out_last, n_out_last;
    logic             out_free;
    t_count           pos_full;

    assign out_free = !r_out_valid || i_rsp_ready;
    assign pos_full = BLOCK_BYTES - r_bytes_left;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_bytes_left = r_bytes_left;
        n_remain     = r_remain;
        n_out_valid  = r_out_valid && !i_rsp_ready;
        n_out_last   = r_out_last;
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        o_cmd.diag   = r_cnt[2];
        o_cmd.sel    = r_cnt[1:0];
        o_cmd.pos    = pos_full[5:0];
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    if (i_req_op == OP_RESTART) begin
                        o_cmd.restart = 1'b1;
                        n_bytes_left  = '0;
                    end else if (i_req_count != '0) begin
                        n_remain = (i_req_count > BLOCK_BYTES) ? BLOCK_BYTES : i_req_count;
                        n_state  = (r_bytes_left == '0) ? ST_INIT : ST_EMIT;
                    end
                end
            end
            ST_INIT: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = ST_ROUND;
            end
            ST_ROUND: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                o_cmd.fin    = 1'b1;
                n_bytes_left = BLOCK_BYTES;
                n_state      = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_last   = (r_remain == 7'd1);
                    n_remain     = r_remain - 7'd1;
                    n_bytes_left = r_bytes_left - 7'd1;
                    if (r_remain == 7'd1) begin
                        n_state = ST_IDLE;
                    end else if (r_bytes_left == 7'd1) begin
                        n_state = ST_INIT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_bytes_left <= '0;
            r_remain     <= '0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_bytes_left <= n_bytes_left;
            r_remain     <= n_remain;
            r_out_valid  <= n_out_valid;
            r_out_last   <= n_out_last;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_last  = r_out_last;

endmodule

// File: src/chacha20_keystream_generator_core.sv
// Top level of the ChaCha20 keystream generator.
`timescale 1ns / 1ps

// ChaCha20 (RFC 8439) keystream generator with a 32-bit block counter that wraps.
// The user must write key, nonce and start counter through the config port while
// the block is idle; the block itself does not enforce this. A restart request or a
// generate request with zero count produces no bytes and leaves the block idle.
// A generate request emits min(count, 64) bytes, one per cycle when the sink is ready
// and no new block is being computed. When the 64-byte block is used up, the next
// block is computed: a load step, then the quarter-round unit runs four lanes in
// parallel and does one add-xor-rotate step per cycle, then a final add step.
module chacha20_keystream_generator_core #(
    parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cc20_req_if.sink                    i_req,
    cc20_rsp_if.source                  o_rsp,
    input  logic                        i_cfg_we,
    input  logic [cc20_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [cc20_pkg::CFG_DW-1:0] i_cfg_wdata
);
    import cc20_pkg::*;

    t_cmd  cmd;
    t_byte out_byte;
    logic  req_ready;
    logic  rsp_valid;
    logic  rsp_last;

    cc20_ctrl #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_op    (i_req.op),
        .i_req_count (i_req.count),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp_last  (rsp_last),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    cc20_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_byte      (out_byte)
    );

    assign i_req.ready       = req_ready;
    assign o_rsp.valid       = rsp_valid;
    assign o_rsp.last        = rsp_last;
    assign o_rsp.stream_byte = out_byte;

endmodule

// File: src/cc20_checker.sv
// Port-level checks for the ChaCha20 keystream generator, bound to the top level.
`timescale 1ns / 1ps

module cc20_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_req_op,
    input cc20_pkg::t_count i_req_count,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input cc20_pkg::t_byte  i_rsp_byte,
    input logic             i_rsp_last
);
    import cc20_pkg::*;

    logic req_acc;
    logic rsp_acc;

    assign req_acc = i_req_valid && i_req_ready;
    assign rsp_acc = i_rsp_valid && i_rsp_ready;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_byte) && $stable(i_rsp_last)))
        else $error("response dropped or changed while stalled");

    a_no_output_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && req_acc && (i_req_op == OP_RESTART || i_req_count == '0)) |=> i_req_ready)
        else $error("restart or empty request did not complete at once");

    a_busy_mid_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_last) |-> !i_req_ready)
        else $error("new request taken before current one finished");

    a_gen_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && req_acc && i_req_op == OP_GENERATE && i_req_count != '0) |=>
            !i_req_ready)
        else $error("generate request did not hold off the next request");

endmodule

bind chacha20_keystream_generator_core cc20_checker u_cc20_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_req_op    (i_req.op),
    .i_req_count (i_req.count),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_byte  (o_rsp.stream_byte),
    .i_rsp_last  (o_rsp.last)
);
